@@ rtl/sih_pkg.sv @@
package sih_pkg;

	localparam int ENTRY_ID_W  = 10;
	localparam int STATUS_W    = 3;
	localparam int DESC_HASH_W = 16;
	localparam int DESC_LEN_W  = 9;
	localparam logic [31:0] HASH_SEED = 32'd5381;
	localparam int HASH_SHIFT  = 5;

	localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

	typedef struct packed {
		logic       operation;
		logic [7:0] key_byte;
		logic       byte_present;
		logic       key_end;
	} key_item_t;

	typedef struct packed {
		logic [ENTRY_ID_W-1:0] entry_id;
		logic [STATUS_W-1:0]   status;
	} result_t;

	// One finished key handed from the front to the back.
	typedef struct packed {
		logic                   op;
		logic                   long_key;
		logic                   bank;
		logic [DESC_LEN_W-1:0]  len;
		logic [DESC_HASH_W-1:0] hash;
	} desc_t;

endpackage

@@ rtl/sih_ram.sv @@
module sih_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/sih_fifo.sv @@
module sih_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	// Two-entry queue.
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

@@ rtl/sih_front.sv @@
module sih_front #(
	parameter int TABLE_SLOTS   = 1024,
	parameter int MAX_KEY_BYTES = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  sih_pkg::key_item_t                    item,
	output logic                                  desc_push,
	output sih_pkg::desc_t                        desc,
	output logic                                  kb_we,
	output logic [$clog2(2*MAX_KEY_BYTES)-1:0]    kb_waddr,
	output logic [7:0]                            kb_wdata
);
	import sih_pkg::*;

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int LEN_W  = $clog2(MAX_KEY_BYTES + 1);
	localparam int KB_AW  = $clog2(2 * MAX_KEY_BYTES);

	logic              active_q;
	logic              op_q;
	logic [SLOT_W-1:0] hash_q;
	logic [LEN_W-1:0]  cnt_q;
	logic              long_q;
	logic              bank_q;

	logic              op_eff;
	logic              room;
	logic [SLOT_W-1:0] hash_n;
	logic [LEN_W-1:0]  cnt_n;
	logic              long_n;
	logic [KB_AW-1:0]  bank_base;

	always_comb begin
		op_eff    = active_q ? op_q : item.operation;
		room      = (cnt_q < LEN_W'(MAX_KEY_BYTES));
		hash_n    = hash_q;
		cnt_n     = cnt_q;
		long_n    = long_q;
		if (item.byte_present) begin
			// h * 33 + byte; only the slot bits matter
			hash_n = (hash_q << HASH_SHIFT) + hash_q + SLOT_W'(32'(item.key_byte));
			if (room) begin
				cnt_n = cnt_q + 1'b1;
			end else begin
				long_n = 1'b1;
			end
		end
		bank_base = bank_q ? KB_AW'(MAX_KEY_BYTES) : '0;
	end

	assign kb_we    = accept && item.byte_present && room;
	assign kb_waddr = bank_base + KB_AW'(cnt_q);
	assign kb_wdata = item.key_byte;

	assign desc_push     = accept && item.key_end;
	assign desc.op       = op_eff;
	assign desc.long_key = long_n;
	assign desc.bank     = bank_q;
	assign desc.len      = DESC_LEN_W'(cnt_n);
	assign desc.hash     = DESC_HASH_W'(hash_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			op_q     <= 1'b0;
			hash_q   <= HASH_SEED[SLOT_W-1:0];
			cnt_q    <= '0;
			long_q   <= 1'b0;
			bank_q   <= 1'b0;
		end else if (accept) begin
			if (item.key_end) begin
				active_q <= 1'b0;
				op_q     <= 1'b0;
				hash_q   <= HASH_SEED[SLOT_W-1:0];
				cnt_q    <= '0;
				long_q   <= 1'b0;
				bank_q   <= !bank_q;
			end else begin
				active_q <= 1'b1;
				op_q     <= op_eff;
				hash_q   <= hash_n;
				cnt_q    <= cnt_n;
				long_q   <= long_n;
			end
		end
	end
endmodule

@@ rtl/sih_back.sv @@
module sih_back #(
	parameter int TABLE_SLOTS   = 1024,
	parameter int MAX_KEY_BYTES = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	output logic                               ready,
	input  logic                               desc_valid,
	input  sih_pkg::desc_t                     desc,
	output logic                               desc_pop,
	output logic [$clog2(2*MAX_KEY_BYTES)-1:0] kb_raddr,
	input  logic [7:0]                         kb_rdata,
	output logic                               res_push,
	output sih_pkg::result_t                   res,
	input  logic                               res_full
);
	import sih_pkg::*;

	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int MAX_ENTRIES = (TABLE_SLOTS / 4) * 3;
	localparam int ID_W        = $clog2(MAX_ENTRIES + 1);
	localparam int E_W         = $clog2(MAX_ENTRIES);
	localparam int LEN_W       = $clog2(MAX_KEY_BYTES + 1);
	localparam int KB_AW       = $clog2(2 * MAX_KEY_BYTES);
	localparam int SB_DEPTH    = MAX_ENTRIES * MAX_KEY_BYTES;
	localparam int SB_AW       = $clog2(SB_DEPTH);

	typedef enum logic [3:0] {
		CLEAR, IDLE, SLOT_RD, SLOT_CHK, LEN_CHK, BYTE_RD, BYTE_CHK,
		COPY_RD, COPY_WR, RESULT
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] clr_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ID_W-1:0]   cur_q;
	logic [SB_AW-1:0]  base_q;
	logic [LEN_W-1:0]  idx_q;
	logic [ID_W-1:0]   count_q;
	result_t           res_q;

	logic              slot_we;
	logic [SLOT_W-1:0] slot_waddr;
	logic [ID_W-1:0]   slot_wdata;
	logic [ID_W-1:0]   slot_rdata;
	logic              len_we;
	logic [LEN_W-1:0]  len_rdata;
	logic [E_W-1:0]    len_raddr;
	logic              sb_we;
	logic [SB_AW-1:0]  sb_addr;
	logic [7:0]        sb_rdata;
	logic [ID_W-1:0]   new_id;
	logic [ID_W-1:0]   hit_m1;
	logic [SLOT_W-1:0] d_hash;
	logic [LEN_W-1:0]  d_len;
	logic [KB_AW-1:0]  kb_base;
	logic              last_idx;

	function automatic logic [ENTRY_ID_W-1:0] to_out_id(input logic [ID_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[ENTRY_ID_W-1:0];
	endfunction

	assign d_hash    = desc.hash[SLOT_W-1:0];
	assign d_len     = desc.len[LEN_W-1:0];
	assign kb_base   = desc.bank ? KB_AW'(MAX_KEY_BYTES) : '0;
	assign kb_raddr  = kb_base + KB_AW'(idx_q);
	assign sb_addr   = base_q + SB_AW'(idx_q);
	assign new_id    = count_q + 1'b1;
	assign hit_m1    = slot_rdata - 1'b1;
	assign len_raddr = E_W'(hit_m1);
	assign last_idx  = (idx_q + 1'b1 == d_len);

	assign ready    = (state_q != CLEAR);
	assign res      = res_q;
	assign res_push = (state_q == RESULT) && !res_full;
	assign desc_pop = res_push;

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = slot_q;
		slot_wdata = new_id;
		len_we     = 1'b0;
		sb_we      = 1'b0;
		case (state_q)
			CLEAR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_q;
				slot_wdata = '0;
			end
			SLOT_CHK: begin
				if (slot_rdata == '0 && desc.op && count_q < ID_W'(MAX_ENTRIES)) begin
					slot_we = 1'b1;
					len_we  = 1'b1;
				end
			end
			COPY_WR: sb_we = 1'b1;
			default: ;
		endcase
	end

	sih_ram #(.WIDTH(ID_W), .DEPTH(TABLE_SLOTS)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(slot_q), .rdata(slot_rdata)
	);

	sih_ram #(.WIDTH(LEN_W), .DEPTH(MAX_ENTRIES)) u_len_ram (
		.clk(clk), .we(len_we), .waddr(E_W'(count_q)), .wdata(d_len),
		.raddr(len_raddr), .rdata(len_rdata)
	);

	sih_ram #(.WIDTH(8), .DEPTH(SB_DEPTH)) u_byte_ram (
		.clk(clk), .we(sb_we), .waddr(sb_addr), .wdata(kb_rdata),
		.raddr(sb_addr), .rdata(sb_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			clr_q   <= '0;
			slot_q  <= '0;
			cur_q   <= '0;
			base_q  <= '0;
			idx_q   <= '0;
			count_q <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(TABLE_SLOTS - 1)) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					idx_q <= '0;
					if (desc_valid) begin
						if (desc.long_key) begin
							res_q   <= '{entry_id: '0, status: ST_TOO_LONG};
							state_q <= RESULT;
						end else begin
							slot_q  <= d_hash;
							state_q <= SLOT_RD;
						end
					end
				end
				SLOT_RD: state_q <= SLOT_CHK;
				SLOT_CHK: begin
					idx_q <= '0;
					if (slot_rdata == '0) begin
						if (!desc.op) begin
							res_q   <= '{entry_id: '0, status: ST_ABSENT};
							state_q <= RESULT;
						end else if (count_q >= ID_W'(MAX_ENTRIES)) begin
							res_q   <= '{entry_id: '0, status: ST_FULL};
							state_q <= RESULT;
						end else begin
							cur_q  <= new_id;
							base_q <= SB_AW'(32'(count_q) * MAX_KEY_BYTES);
							if (d_len == '0) begin
								count_q <= new_id;
								res_q   <= '{entry_id: to_out_id(new_id),
								            status: ST_INSERTED};
								state_q <= RESULT;
							end else begin
								state_q <= COPY_RD;
							end
						end
					end else begin
						cur_q   <= slot_rdata;
						base_q  <= SB_AW'(32'(hit_m1) * MAX_KEY_BYTES);
						state_q <= LEN_CHK;
					end
				end
				LEN_CHK: begin
					if (len_rdata != d_len) begin
						slot_q  <= slot_q + 1'b1;
						state_q <= SLOT_RD;
					end else if (d_len == '0) begin
						res_q   <= '{entry_id: to_out_id(cur_q), status: ST_FOUND};
						state_q <= RESULT;
					end else begin
						state_q <= BYTE_RD;
					end
				end
				BYTE_RD: state_q <= BYTE_CHK;
				BYTE_CHK: begin
					if (sb_rdata != kb_rdata) begin
						slot_q  <= slot_q + 1'b1;
						state_q <= SLOT_RD;
					end else if (last_idx) begin
						res_q   <= '{entry_id: to_out_id(cur_q), status: ST_FOUND};
						state_q <= RESULT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= BYTE_RD;
					end
				end
				COPY_RD: state_q <= COPY_WR;
				COPY_WR: begin
					if (last_idx) begin
						count_q <= cur_q;
						res_q   <= '{entry_id: to_out_id(cur_q), status: ST_INSERTED};
						state_q <= RESULT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= COPY_RD;
					end
				end
				RESULT: begin
					if (!res_full) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_result_has_key: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == RESULT |-> desc_valid)
		else $error("result pending without a key in the queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ID_W'(MAX_ENTRIES))
		else $error("entry count beyond table capacity");

	a_claim_empty_slot: assert property (@(posedge clk) disable iff (!arst_n)
		slot_we && state_q != CLEAR |-> slot_rdata == '0)
		else $error("insert overwrote an occupied slot");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> state_q == IDLE)
		else $error("engine did not return to idle after a transfer");
endmodule

@@ rtl/string_interning_hash_table_core.sv @@
// String intern table. Key bytes are pushed one per cycle while the key
// queue has room and the reset sweep is over; each finished key gets one
// result: the id of the existing entry, a fresh id for an insert, or a
// status code for absent, table full or key too long. Lookup time per key
// is set by the probe engine, which walks memories with a registered read:
// it reads each probed slot, the stored length of an occupied slot, then
// compares the key bytes one by one, and on insert copies the key bytes.
// Two keys can be buffered between the byte side and the probe engine, and
// two results wait on the output side. After reset the slot table is swept
// to zero, one slot a cycle; full stays high meanwhile. TABLE_SLOTS must be
// a power of two; the block itself does not check this.
module string_interning_hash_table_core #(
	parameter int TABLE_SLOTS   = 1024,
	parameter int MAX_KEY_BYTES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  sih_pkg::key_item_t  key_item,
	input  logic                pop,
	output logic                empty,
	output sih_pkg::result_t    result
);
	import sih_pkg::*;

	localparam int KB_AW = $clog2(2 * MAX_KEY_BYTES);

	logic             accept;
	logic             desc_push;
	desc_t            desc_in;
	desc_t            desc_out;
	logic             desc_full;
	logic             desc_empty;
	logic             desc_pop;
	logic             back_ready;
	logic             kb_we;
	logic [KB_AW-1:0] kb_waddr;
	logic [7:0]       kb_wdata;
	logic [KB_AW-1:0] kb_raddr;
	logic [7:0]       kb_rdata;
	logic             res_push;
	result_t          res;
	logic             res_full;

	// Hold off bytes while both key banks are taken or the slot sweep runs.
	assign full   = desc_full || !back_ready;
	assign accept = push && !full;

	sih_front #(.TABLE_SLOTS(TABLE_SLOTS), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .item(key_item),
		.desc_push(desc_push), .desc(desc_in),
		.kb_we(kb_we), .kb_waddr(kb_waddr), .kb_wdata(kb_wdata)
	);

	// Two banks of key bytes, one per queued key.
	sih_ram #(.WIDTH(8), .DEPTH(2 * MAX_KEY_BYTES)) u_key_buf (
		.clk(clk), .we(kb_we), .waddr(kb_waddr), .wdata(kb_wdata),
		.raddr(kb_raddr), .rdata(kb_rdata)
	);

	// The back pops a key only when its result transfers, so the bank stays
	// owned until then.
	sih_fifo #(.WIDTH($bits(desc_t))) u_desc_q (
		.clk(clk), .arst_n(arst_n), .push(desc_push), .wdata(desc_in),
		.full(desc_full), .pop(desc_pop), .rdata(desc_out), .empty(desc_empty)
	);

	sih_back #(.TABLE_SLOTS(TABLE_SLOTS), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n), .ready(back_ready),
		.desc_valid(!desc_empty), .desc(desc_out), .desc_pop(desc_pop),
		.kb_raddr(kb_raddr), .kb_rdata(kb_rdata),
		.res_push(res_push), .res(res), .res_full(res_full)
	);

	sih_fifo #(.WIDTH($bits(result_t))) u_res_q (
		.clk(clk), .arst_n(arst_n), .push(res_push), .wdata(res),
		.full(res_full), .pop(pop), .rdata(result), .empty(empty)
	);
endmodule
